// File: rtl/py2r_pkg.sv
package py2r_pkg;

  // Byte order codes
  localparam logic ORDER_YUY2 = 1'b0;
  localparam logic ORDER_UYVY = 1'b1;

  // BT.601 video range coefficients, sized for the 19-bit product/sum path
  localparam int unsigned SumW = 19;

  localparam logic signed [SumW-1:0] K_Y     = 19'sd298;
  localparam logic signed [SumW-1:0] K_CR_R  = 19'sd409;
  localparam logic signed [SumW-1:0] K_CB_G  = 19'sd100;
  localparam logic signed [SumW-1:0] K_CR_G  = 19'sd208;
  localparam logic signed [SumW-1:0] K_CB_B  = 19'sd516;
  localparam logic signed [SumW-1:0] K_ROUND = 19'sd128;

  localparam logic signed [8:0] LUMA_OFS   = 9'sd16;
  localparam logic signed [8:0] CHROMA_OFS = 9'sd128;

  localparam logic [7:0] CHAN_MAX = 8'd255;
  localparam logic [7:0] ALPHA    = 8'd0;

  typedef struct packed {
    logic [31:0] packed_word;
    logic        frame_end_in;
  } in_t;

  typedef struct packed {
    logic [31:0] first_pixel;
    logic [31:0] second_pixel;
    logic        frame_end_out;
  } out_t;

  // Per-stage load strobes from the handshake control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// File: rtl/py2r_core.sv
module py2r_core (
  input  logic                 clk_i,
  input  logic                 byte_order_i,
  input  py2r_pkg::stage_en_t  en_i,
  input  py2r_pkg::in_t        in_i,
  output py2r_pkg::out_t       out_o
);

  localparam int unsigned W = py2r_pkg::SumW;

  // Stage 1: unpack and remove offsets
  logic [7:0] y0, y1, cb, cr;
  logic signed [8:0] c0_d, c1_d, d_d, e_d;
  logic signed [8:0] c0_q, c1_q, d_q, e_q;
  logic              fe1_q;

  always_comb begin
    unique case (byte_order_i)
      py2r_pkg::ORDER_UYVY: begin
        cb = in_i.packed_word[7:0];
        y0 = in_i.packed_word[15:8];
        cr = in_i.packed_word[23:16];
        y1 = in_i.packed_word[31:24];
      end
      default: begin
        y0 = in_i.packed_word[7:0];
        cb = in_i.packed_word[15:8];
        y1 = in_i.packed_word[23:16];
        cr = in_i.packed_word[31:24];
      end
    endcase
    c0_d = $signed({1'b0, y0}) - py2r_pkg::LUMA_OFS;
    c1_d = $signed({1'b0, y1}) - py2r_pkg::LUMA_OFS;
    d_d  = $signed({1'b0, cb}) - py2r_pkg::CHROMA_OFS;
    e_d  = $signed({1'b0, cr}) - py2r_pkg::CHROMA_OFS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      c0_q  <= c0_d;
      c1_q  <= c1_d;
      d_q   <= d_d;
      e_q   <= e_d;
      fe1_q <= in_i.frame_end_in;
    end
  end

  // Stage 2: constant products; chroma terms shared by both pixels
  logic signed [W-1:0] c0_x, c1_x, d_x, e_x;
  logic signed [W-1:0] py0_q, py1_q, prv_q, pgu_q, pgv_q, pbu_q;
  logic                fe2_q;

  assign c0_x = W'(c0_q);
  assign c1_x = W'(c1_q);
  assign d_x  = W'(d_q);
  assign e_x  = W'(e_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      py0_q <= c0_x * py2r_pkg::K_Y;
      py1_q <= c1_x * py2r_pkg::K_Y;
      prv_q <= e_x * py2r_pkg::K_CR_R;
      pgu_q <= d_x * py2r_pkg::K_CB_G;
      pgv_q <= e_x * py2r_pkg::K_CR_G;
      pbu_q <= d_x * py2r_pkg::K_CB_B;
      fe2_q <= fe1_q;
    end
  end

  // Stage 3: channel sums with rounding
  logic signed [W-1:0] r0_q, g0_q, b0_q, r1_q, g1_q, b1_q;
  logic                fe3_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      r0_q  <= py0_q + prv_q + py2r_pkg::K_ROUND;
      g0_q  <= py0_q - pgu_q - pgv_q + py2r_pkg::K_ROUND;
      b0_q  <= py0_q + pbu_q + py2r_pkg::K_ROUND;
      r1_q  <= py1_q + prv_q + py2r_pkg::K_ROUND;
      g1_q  <= py1_q - pgu_q - pgv_q + py2r_pkg::K_ROUND;
      b1_q  <= py1_q + pbu_q + py2r_pkg::K_ROUND;
      fe3_q <= fe2_q;
    end
  end

  // Stage 4: floor shift by 8 and clip to 0..255
  function automatic logic [7:0] clip8(logic signed [W-1:0] s);
    logic [7:0] v;
    priority if (s[W-1]) begin
      v = 8'd0;
    end else if (|s[W-2:16]) begin
      v = py2r_pkg::CHAN_MAX;
    end else begin
      v = s[15:8];
    end
    return v;
  endfunction

  py2r_pkg::out_t out_d, out_q;

  always_comb begin
    out_d.first_pixel   = {py2r_pkg::ALPHA, clip8(r0_q), clip8(g0_q), clip8(b0_q)};
    out_d.second_pixel  = {py2r_pkg::ALPHA, clip8(r1_q), clip8(g1_q), clip8(b1_q)};
    out_d.frame_end_out = fe3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// File: rtl/packed_yuv422_to_rgb32.sv
// Channel  Dir  Handshake             Payload
// in       in   in_valid_i/in_ready_o  py2r_pkg::in_t  (packed word, frame end)
// out      out  out_valid_o/out_ready_i py2r_pkg::out_t (two RGB32 pixels, frame end)
// cfg      in   cfg_we_i               cfg_wdata_i (byte order)
//
// Four register stages: unpack/offset, multiply, sum, clip. A word accepted into stage 1
// moves through each stage to the output register; one word per clock sustained while out_ready_i is high.
// Each stage loads when it is empty or the stage after it moves, so bubbles fill
// in and a stalled output holds the whole pipe without loss.
// Reset clears the valid bits and sets byte order to YUY2.
module packed_yuv422_to_rgb32 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  py2r_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output py2r_pkg::out_t  out_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i
);

  logic byte_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= py2r_pkg::ORDER_YUY2;
    end else if (cfg_we_i) begin
      byte_order_q <= cfg_wdata_i;
    end
  end

  // Valid chain: v_q[0] is stage 1, v_q[3] is the output register
  logic [3:0] v_q, v_d, rdy;
  py2r_pkg::stage_en_t en;

  always_comb begin
    rdy[3] = !v_q[3] || out_ready_i;
    rdy[2] = !v_q[2] || rdy[3];
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];

    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    v_d[1] = rdy[1] ? v_q[0]     : v_q[1];
    v_d[2] = rdy[2] ? v_q[1]     : v_q[2];
    v_d[3] = rdy[3] ? v_q[2]     : v_q[3];

    en.s1 = rdy[0] && in_valid_i;
    en.s2 = rdy[1] && v_q[0];
    en.s3 = rdy[2] && v_q[1];
    en.s4 = rdy[3] && v_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];

  py2r_core u_core (
    .clk_i        (clk_i),
    .byte_order_i (byte_order_q),
    .en_i         (en),
    .in_i         (in_i),
    .out_o        (out_o)
  );

endmodule
